[hdl/tt_pkg.sv]
package tt_pkg;

    // Event codes carried in the operation field
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_FIRE   = 3'd1;
    localparam logic [2:0] OP_EXPIRE = 3'd2;
    localparam logic [2:0] OP_HEARD  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DOUBLINGS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REDUNDANCY_K  = 2'd2;

    // Smallest usable Imin
    localparam logic [30:0] MIN_INTERVAL_FLOOR = 31'd2;
    // Saturation point of the consistency counter
    localparam logic [7:0] HEARD_MAX = 8'hFF;

    // Input event
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now;
        logic [31:0] offset_ms;
    } tt_in_t;

    // Result of one event
    typedef struct packed {
        logic        ok;
        logic        send;
        logic        event_kind;
        logic [31:0] event_time;
    } tt_out_t;

    // Decoded configuration handed to the timer core
    typedef struct packed {
        logic        valid;
        logic [30:0] min_interval;
        logic [31:0] imax;
        logic [7:0]  redundancy_k;
    } tt_cfg_t;

endpackage

[hdl/tt_cfg.sv]
module tt_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tt_pkg::tt_cfg_t                 cfg
);

    logic [30:0] min_interval_reg;
    logic [4:0]  max_doublings_reg;
    logic [7:0]  redundancy_k_reg;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] imax_reg;
    logic [31:0] imax_next;
    logic [61:0] shifted;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg  <= '0;
            max_doublings_reg <= '0;
            redundancy_k_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tt_pkg::CFG_MIN_INTERVAL:  min_interval_reg  <= cfg_data[30:0];
                tt_pkg::CFG_MAX_DOUBLINGS: max_doublings_reg <= cfg_data[4:0];
                tt_pkg::CFG_REDUNDANCY_K:  redundancy_k_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Imax = Imin << doublings; must stay within 31 bits
    always_comb
    begin
        shifted    = {31'd0, min_interval_reg} << max_doublings_reg;
        imax_next  = shifted[31:0];
        valid_next = (min_interval_reg >= tt_pkg::MIN_INTERVAL_FLOOR)
                     && (redundancy_k_reg != 8'd0)
                     && (shifted[61:31] == 31'd0);
    end

    // Derived values, registered from the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            imax_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            imax_reg  <= imax_next;
        end
    end

    assign cfg.valid        = valid_reg;
    assign cfg.min_interval = min_interval_reg;
    assign cfg.imax         = imax_reg;
    assign cfg.redundancy_k = redundancy_k_reg;

endmodule

[hdl/tt_core.sv]
module tt_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tt_pkg::tt_in_t   item,
    input  tt_pkg::tt_cfg_t  cfg,
    output tt_pkg::tt_out_t  result
);

    logic [31:0] cur_interval_reg,   cur_interval_next;
    logic [31:0] interval_begin_reg, interval_begin_next;
    logic [31:0] send_deadline_reg,  send_deadline_next;
    logic [7:0]  heard_count_reg,    heard_count_next;
    logic        running_reg,        running_next;
    logic        sent_reg,           sent_next;

    logic [31:0] grown;
    logic [31:0] open_len;
    logic [31:0] half;
    logic [31:0] span;
    logic        open_ok;
    logic [31:0] deadline;

    // Length of a new interval: Imin on start, doubled up to Imax on expiry; also offset check and send deadline
    always_comb
    begin
        grown    = (cur_interval_reg > {1'b0, cfg.imax[31:1]})
                   ? cfg.imax : {cur_interval_reg[30:0], 1'b0};
        open_len = (item.operation == tt_pkg::OP_EXPIRE)
                   ? grown : {1'b0, cfg.min_interval};
        span     = {1'b0, open_len[31:1]};
        half     = span + {31'd0, open_len[0]};
        open_ok  = (span != 32'd0) && (item.offset_ms < span);
        deadline = item.now + half + item.offset_ms;
    end

    // Event handling
    always_comb
    begin
        cur_interval_next   = cur_interval_reg;
        interval_begin_next = interval_begin_reg;
        send_deadline_next  = send_deadline_reg;
        heard_count_next    = heard_count_reg;
        running_next        = running_reg;
        sent_next           = sent_reg;
        result              = '0;

        if (step && cfg.valid)
        begin
            case (item.operation)
                tt_pkg::OP_START, tt_pkg::OP_EXPIRE:
                begin
                    if ((item.operation == tt_pkg::OP_START
                         || (running_reg && sent_reg)) && open_ok)
                    begin
                        result.ok           = 1'b1;
                        cur_interval_next   = open_len;
                        interval_begin_next = item.now;
                        heard_count_next    = '0;
                        running_next        = 1'b1;
                        sent_next           = 1'b0;
                        send_deadline_next  = deadline;
                    end
                end
                tt_pkg::OP_FIRE:
                begin
                    if (running_reg && !sent_reg)
                    begin
                        result.ok   = 1'b1;
                        result.send = (heard_count_reg < cfg.redundancy_k);
                        sent_next   = 1'b1;
                    end
                end
                tt_pkg::OP_HEARD:
                begin
                    if (running_reg)
                    begin
                        result.ok = 1'b1;
                        if (heard_count_reg != tt_pkg::HEARD_MAX)
                        begin
                            heard_count_next = heard_count_reg + 8'd1;
                        end
                    end
                end
                tt_pkg::OP_QUERY:
                begin
                    if (running_reg)
                    begin
                        result.ok         = 1'b1;
                        result.event_kind = sent_reg;
                        result.event_time = sent_reg
                                            ? (interval_begin_reg + cur_interval_reg)
                                            : send_deadline_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_interval_reg   <= '0;
            interval_begin_reg <= '0;
            send_deadline_reg  <= '0;
            heard_count_reg    <= '0;
            running_reg        <= 1'b0;
            sent_reg           <= 1'b0;
        end
        else
        begin
            cur_interval_reg   <= cur_interval_next;
            interval_begin_reg <= interval_begin_next;
            send_deadline_reg  <= send_deadline_next;
            heard_count_reg    <= heard_count_next;
            running_reg        <= running_next;
            sent_reg           <= sent_next;
        end
    end

endmodule

[hdl/trickle_timer_unit.sv]
// Trickle timer: one result per event.
// An accepted event is held in the input register, then goes once through the
// event logic into the output register; a stalled result keeps it waiting.
// Throughput: one event per cycle while no stalled result holds the pipeline.
// Reset (rst_n low, asynchronous): configuration, timer state and both
// pipeline valid flags clear; the timer is stopped and the block unconfigured.
module trickle_timer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tt_pkg::tt_in_t                  in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tt_pkg::tt_out_t                 out_data
);

    tt_pkg::tt_cfg_t cfg;
    tt_pkg::tt_in_t  in_item_reg;
    tt_pkg::tt_out_t out_data_reg;
    tt_pkg::tt_out_t result;
    logic            in_valid_reg,  in_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;
    logic            advance;
    logic            accept;

    tt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tt_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Pipeline handshake
    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        advance        = in_valid_reg && out_free;
        in_stall       = in_valid_reg && !out_free;
        accept         = in_valid && !in_stall;
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[bench/trickle_timer_checker.sv]
`timescale 1ns / 100ps

module trickle_timer_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  tt_pkg::tt_in_t                 in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  tt_pkg::tt_out_t                out_data,
    output int unsigned                    outstanding,
    output int unsigned                    mismatches
);

    // Shadow configuration
    logic [30:0] imin;
    logic [4:0]  doublings;
    logic [7:0]  k_redund;

    // Shadow timer state
    logic [31:0] ivl_len;
    logic [31:0] ivl_start;
    logic [31:0] tx_deadline;
    logic [7:0]  heard;
    logic        active;
    logic        tx_done;

    // Responses still owed by the block, oldest first
    tt_pkg::tt_out_t owed_responses[$];
    tt_pkg::tt_out_t want;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        begin
            mismatches++;
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h",
                     $time, field, got, exp_val);
        end
    endtask

    // {valid, longest interval} for the current configuration
    function automatic logic [32:0] interval_cap();
        logic [63:0] wide;
        wide = 64'(imin) << doublings;
        if (imin < tt_pkg::MIN_INTERVAL_FLOOR || k_redund == 8'd0
            || wide > 64'h7FFF_FFFF)
            return 33'd0;
        return {1'b1, wide[31:0]};
    endfunction

    // Open a new interval; refused when the offset misses the second half
    task automatic open_interval(input logic [31:0] len, input logic [31:0] now_ms,
                                 input logic [31:0] offs, output logic took);
        logic [31:0] half;
        logic [31:0] span;
        half = (len >> 1) + (len & 32'd1);
        span = len - half;
        if (span == 32'd0 || offs >= span)
        begin
            took = 1'b0;
        end
        else
        begin
            ivl_len     = len;
            ivl_start   = now_ms;
            heard       = 8'd0;
            active      = 1'b1;
            tx_done     = 1'b0;
            tx_deadline = now_ms + half + offs;
            took        = 1'b1;
        end
    endtask

    // Response to one event, updating the shadow state
    task automatic trickle_response(input tt_pkg::tt_in_t ev, output tt_pkg::tt_out_t res);
        logic [32:0] cap;
        logic [31:0] longest;
        logic [31:0] next_len;
        logic        took;
        res = '0;
        cap = interval_cap();
        if (cap[32])
        begin
            longest = cap[31:0];
            case (ev.operation)
                tt_pkg::OP_START:
                begin
                    open_interval({1'b0, imin}, ev.now, ev.offset_ms, took);
                    res.ok = took;
                end
                tt_pkg::OP_FIRE:
                begin
                    if (active && !tx_done)
                    begin
                        res.ok   = 1'b1;
                        res.send = heard < k_redund;
                        tx_done  = 1'b1;
                    end
                end
                tt_pkg::OP_EXPIRE:
                begin
                    if (active && tx_done)
                    begin
                        // double, but never past the longest interval
                        next_len = (ivl_len > (longest >> 1)) ? longest : ivl_len << 1;
                        open_interval(next_len, ev.now, ev.offset_ms, took);
                        res.ok = took;
                    end
                end
                tt_pkg::OP_HEARD:
                begin
                    if (active)
                    begin
                        res.ok = 1'b1;
                        if (heard != tt_pkg::HEARD_MAX)
                            heard++;
                    end
                end
                tt_pkg::OP_QUERY:
                begin
                    if (active)
                    begin
                        res.ok = 1'b1;
                        if (!tx_done)
                        begin
                            res.event_kind = 1'b0;
                            res.event_time = tx_deadline;
                        end
                        else
                        begin
                            res.event_kind = 1'b1;
                            res.event_time = ivl_start + ivl_len;
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    endtask

    // Watch both channels and the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imin        = '0;
            doublings   = '0;
            k_redund    = '0;
            ivl_len     = '0;
            ivl_start   = '0;
            tx_deadline = '0;
            heard       = '0;
            active      = 1'b0;
            tx_done     = 1'b0;
            mismatches  = 0;
            owed_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tt_pkg::CFG_MIN_INTERVAL:  imin      = cfg_data[30:0];
                    tt_pkg::CFG_MAX_DOUBLINGS: doublings = cfg_data[4:0];
                    tt_pkg::CFG_REDUNDANCY_K:  k_redund  = cfg_data[7:0];
                    default:                   ;
                endcase
            end

            // result transfer: check against the oldest owed response
            if (out_valid && !out_stall)
            begin
                if (owed_responses.size() == 0)
                begin
                    report_mismatch("unexpected result", out_data.event_time, 32'd0);
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (out_data.ok !== want.ok)
                        report_mismatch("ok", 32'(out_data.ok), 32'(want.ok));
                    if (out_data.send !== want.send)
                        report_mismatch("send", 32'(out_data.send), 32'(want.send));
                    if (out_data.event_kind !== want.event_kind)
                        report_mismatch("event_kind", 32'(out_data.event_kind),
                                        32'(want.event_kind));
                    if (out_data.event_time !== want.event_time)
                        report_mismatch("event_time", out_data.event_time, want.event_time);
                end
            end

            // event transfer: work out what the block owes
            if (in_valid && !in_stall)
            begin
                trickle_response(in_data, want);
                owed_responses.push_back(want);
            end

            outstanding <= owed_responses.size();
        end
    end

endmodule

[bench/trickle_timer_unit_test.sv]
`timescale 1ns / 100ps

module trickle_timer_unit_test;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tt_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    tt_pkg::tt_in_t                 in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    tt_pkg::tt_out_t                out_data;
    int unsigned                    outstanding;
    int unsigned                    mismatches;

    // Stimulus bookkeeping
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned issued    = 0;
    logic [30:0] cur_min   = '0;
    logic [31:0] cur_max   = '0;
    logic [31:0] est_len   = '0;
    logic [31:0] clock_ms  = '0;

    trickle_timer_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    trickle_timer_checker checker_inst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // One event transfer, with random sender gaps ahead of it
    task automatic send_event(input logic [2:0] op, input logic [31:0] now_ms,
                              input logic [31:0] offs);
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{operation: op, now: now_ms, offset_ms: offs};
            do
                @(posedge clk);
            while (in_stall);
            issued++;
        end
    endtask

    // Stop sending and wait for every owed result
    task automatic drain();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (outstanding != 0);
            repeat (3) @(posedge clk);
        end
    endtask

    task automatic configure(input logic [30:0] m, input logic [4:0] d,
                             input logic [7:0] k);
        logic [63:0] wide;
        begin
            drain();
            cfg_we    <= 1'b1;
            cfg_index <= tt_pkg::CFG_MIN_INTERVAL;
            cfg_data  <= m;
            @(posedge clk);
            cfg_index <= tt_pkg::CFG_MAX_DOUBLINGS;
            cfg_data  <= tt_pkg::CFG_DATA_W'(d);
            @(posedge clk);
            cfg_index <= tt_pkg::CFG_REDUNDANCY_K;
            cfg_data  <= tt_pkg::CFG_DATA_W'(k);
            @(posedge clk);
            cfg_we    <= 1'b0;
            @(posedge clk);
            wide    = 64'(m) << d;
            cur_min = m;
            cur_max = (wide > 64'h7FFF_FFFF) ? 32'd0 : wide[31:0];
        end
    endtask

    task automatic set_pace(input pace_t pace);
        begin
            idle_pct  = (pace == PACE_SENDER_GAPS) ? 66 : (pace == PACE_BOTH) ? 10 : 0;
            stall_pct <= (pace == PACE_RECEIVER_STALLS) ? 66 : (pace == PACE_BOTH) ? 10 : 0;
        end
    endtask

    // Move the time base on; now and then jump anywhere
    task automatic step_clock();
        int r;
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                clock_ms = $urandom;
            else if (r < 10)
                clock_ms += $urandom_range(0, 3);
            else
                clock_ms += est_len >> $urandom_range(0, 4);
        end
    endtask

    // Offset for an interval of length len: mostly legal, sometimes on or past the edge
    function automatic logic [31:0] pick_offset(input logic [31:0] len);
        logic [31:0] span;
        int          r;
        span = len >> 1;
        r    = $urandom_range(0, 99);
        if (span == 32'd0 || r >= 90)
            return $urandom;
        if (r < 70)
            return $urandom_range(0, span - 1);
        if (r < 80)
            return span - 1;
        return span;
    endfunction

    // A few random events of any kind
    task automatic send_noise();
        logic [2:0]  op;
        logic [31:0] offs;
        int          n;
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                op   = 3'($urandom_range(0, 7));
                offs = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 3));
                send_event(op, $urandom, offs);
                if (op == tt_pkg::OP_START && offs < 32'(cur_min >> 1))
                    est_len = {1'b0, cur_min};
            end
        end
    endtask

    // Well-formed interval life: optional start, then rounds of heard, fire, expire, with queries and noise
    task automatic run_sequence(input bit open_new, input bit flood);
        logic [31:0] offs;
        logic [31:0] next_len;
        int          rounds;
        int          n;
        begin
            rounds = $urandom_range(1, 4);
            if (open_new)
            begin
                step_clock();
                offs = pick_offset({1'b0, cur_min});
                send_event(tt_pkg::OP_START, clock_ms, offs);
                if (offs < 32'(cur_min >> 1))
                    est_len = {1'b0, cur_min};
            end
            for (int r = 0; r < rounds; r++)
            begin
                n = (flood && r == 0) ? $urandom_range(253, 258) : $urandom_range(0, 3);
                repeat (n)
                    send_event(tt_pkg::OP_HEARD, $urandom, $urandom);
                if ($urandom_range(0, 1))
                    send_event(tt_pkg::OP_QUERY, $urandom, $urandom);
                step_clock();
                send_event(tt_pkg::OP_FIRE, clock_ms, $urandom);
                if ($urandom_range(0, 2) == 0)
                    send_event(tt_pkg::OP_QUERY, $urandom, $urandom);
                if ($urandom_range(0, 99) < 15)
                    send_noise();
                step_clock();
                next_len = (est_len > (cur_max >> 1)) ? cur_max : est_len << 1;
                offs     = pick_offset(next_len);
                send_event(tt_pkg::OP_EXPIRE, clock_ms, offs);
                if (offs < (next_len >> 1))
                    est_len = next_len;
            end
        end
    endtask

    task automatic run_phase(input logic [30:0] m, input logic [4:0] d, input logic [7:0] k,
                             input pace_t pace, input int unsigned budget, input bit floods);
        int unsigned first;
        int          seq;
        begin
            configure(m, d, k);
            set_pace(pace);
            first = issued;
            seq   = 0;
            // the first sequence carries on the interval left by the last phase
            while (issued - first < budget)
            begin
                run_sequence(seq != 0 && $urandom_range(0, 3) != 0,
                             floods && seq == 1);
                seq++;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unconfigured block refuses everything
        send_event(tt_pkg::OP_START, 32'd0, 32'd0);

        // Imin 7, longest 28, k 1
        configure(31'd7, 5'd2, 8'd1);
        send_event(tt_pkg::OP_FIRE, 32'd1, 32'd0);
        send_event(tt_pkg::OP_QUERY, 32'd1, 32'd0);
        send_event(tt_pkg::OP_START, 32'd5, 32'd3);
        send_event(tt_pkg::OP_START, 32'hFFFF_FFFE, 32'd2);
        send_event(tt_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0);
        send_event(tt_pkg::OP_EXPIRE, 32'd2, 32'd0);
        send_event(tt_pkg::OP_HEARD, 32'd2, 32'hFFFF_FFFF);
        send_event(tt_pkg::OP_FIRE, 32'd3, 32'd0);
        send_event(tt_pkg::OP_FIRE, 32'd3, 32'd0);
        send_event(tt_pkg::OP_QUERY, 32'd4, 32'd0);
        send_event(tt_pkg::OP_EXPIRE, 32'd5, 32'hFFFF_FFFF);
        send_event(tt_pkg::OP_EXPIRE, 32'd5, 32'd0);
        send_event(tt_pkg::OP_FIRE, 32'd14, 32'd0);
        send_event(tt_pkg::OP_EXPIRE, 32'd19, 32'd13);
        send_event(tt_pkg::OP_FIRE, 32'd40, 32'd0);
        send_event(tt_pkg::OP_EXPIRE, 32'd47, 32'd0);
        send_event(tt_pkg::OP_QUERY, 32'd50, 32'd0);
        for (int u = 1; u <= 3; u++)
            send_event(tt_pkg::OP_QUERY + 3'(u), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(tt_pkg::OP_HEARD, 32'd60, 32'd0);
        send_event(tt_pkg::OP_START, 32'd0, 32'd0);
        est_len = 32'd7;

        // random part across configurations and pacing
        run_phase(31'd2, 5'd0, 8'd1, PACE_FULL, 110, 1'b0);
        run_phase(31'd2, 5'd29, 8'd3, PACE_SENDER_GAPS, 130, 1'b0);
        run_phase(31'h7FFF_FFFF, 5'd0, tt_pkg::HEARD_MAX, PACE_RECEIVER_STALLS, 100, 1'b0);
        run_phase(31'd3, 5'd29, 8'd2, PACE_BOTH, 140, 1'b0);
        // much smaller maximum while a long interval runs
        run_phase(31'd9, 5'd1, 8'd2, PACE_SENDER_GAPS, 90, 1'b0);
        // unusable settings
        run_phase(31'd1, 5'd4, 8'd2, PACE_RECEIVER_STALLS, 25, 1'b0);
        run_phase(31'd100, 5'd4, 8'd0, PACE_BOTH, 25, 1'b0);
        run_phase(31'h7FFF_FFFF, 5'd1, 8'd5, PACE_FULL, 25, 1'b0);
        run_phase(31'd5, 5'd31, 8'd1, PACE_SENDER_GAPS, 25, 1'b0);
        // counter driven to saturation
        run_phase(31'd100, 5'd3, tt_pkg::HEARD_MAX, PACE_RECEIVER_STALLS, 300, 1'b1);
        run_phase(31'd6, 5'd2, 8'd4, PACE_BOTH, 80, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[trickle_timer_unit.f]
hdl/tt_pkg.sv
hdl/tt_cfg.sv
hdl/tt_core.sv
hdl/trickle_timer_unit.sv
bench/trickle_timer_checker.sv
bench/trickle_timer_unit_test.sv
